FILE: hw/rtl/json_string_escaper_macros.svh
// Assertion macros shared by the escaper RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n
// in the module that uses it.
`ifndef JSON_STRING_ESCAPER_MACROS_SVH
`define JSON_STRING_ESCAPER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/jse_pkg.sv
`timescale 1ns / 1ps

package jse_pkg;

    // Character codes used by the escaper.
    localparam logic [7:0] CHR_NUL       = 8'h00;
    localparam logic [7:0] CHR_TAB       = 8'h09;
    localparam logic [7:0] CHR_LF        = 8'h0A;
    localparam logic [7:0] CHR_CR        = 8'h0D;
    localparam logic [7:0] CHR_QUOTE     = 8'h22;
    localparam logic [7:0] CHR_ZERO      = 8'h30;
    localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHR_LOWER_N   = 8'h6E;
    localparam logic [7:0] CHR_LOWER_R   = 8'h72;
    localparam logic [7:0] CHR_LOWER_T   = 8'h74;
    localparam logic [7:0] CHR_LOWER_U   = 8'h75;
    localparam logic [7:0] CHR_SPACE     = 8'h20;

    // Sequence lengths.
    localparam int          SEQ_MAX        = 6;
    localparam int          LEN_W          = 3;
    localparam logic [2:0]  LEN_NONE       = 3'd0;
    localparam logic [2:0]  LEN_ONE        = 3'd1;
    localparam logic [2:0]  LEN_SHORT_ESC  = 3'd2;
    localparam logic [2:0]  LEN_LONG_ESC   = 3'd6;

    // One expanded output sequence; data[0] leaves first.
    typedef struct packed {
        logic [SEQ_MAX-1:0][7:0] data;
        logic [LEN_W-1:0]        len;
        logic                    last;
    } seq_t;

    // Lowercase hex digit for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] wide;
        begin
            wide = {4'h0, nib};
            if (nib < 4'd10)
            begin
                hex_digit = CHR_ZERO + wide;
            end
            else
            begin
                hex_digit = 8'h57 + wide;
            end
        end
    endfunction

endpackage

FILE: hw/rtl/jse_encode.sv
`timescale 1ns / 1ps

module jse_encode (
    input  logic [7:0]    in_byte,
    input  logic [15:0]   capacity,
    input  logic [15:0]   count,
    output jse_pkg::seq_t seq,
    output logic [15:0]   count_next
);

    logic [16:0] cnt_plus2;
    logic [16:0] cnt_plus6;
    logic [16:0] cap_ext;
    logic        room_short;
    logic        room_long;
    logic [7:0]  esc_chr;

    // Room checks run at 17 bits so that the sum never wraps.
    assign cap_ext    = {1'b0, capacity};
    assign cnt_plus2  = {1'b0, count} + 17'd2;
    assign cnt_plus6  = {1'b0, count} + 17'd6;
    assign room_short = cnt_plus2 < cap_ext;
    assign room_long  = cnt_plus6 < cap_ext;

    // Second character of the two-byte escapes; NUL means no short escape.
    always_comb
    begin
        case (in_byte)
            jse_pkg::CHR_QUOTE:     esc_chr = jse_pkg::CHR_QUOTE;
            jse_pkg::CHR_BACKSLASH: esc_chr = jse_pkg::CHR_BACKSLASH;
            jse_pkg::CHR_LF:        esc_chr = jse_pkg::CHR_LOWER_N;
            jse_pkg::CHR_CR:        esc_chr = jse_pkg::CHR_LOWER_R;
            jse_pkg::CHR_TAB:       esc_chr = jse_pkg::CHR_LOWER_T;
            default:                esc_chr = jse_pkg::CHR_NUL;
        endcase
    end

    // Build the output sequence for this byte.
    always_comb
    begin
        seq.data = '0;
        seq.len  = jse_pkg::LEN_NONE;
        seq.last = 1'b0;
        if (in_byte == jse_pkg::CHR_NUL)
        begin
            seq.last = 1'b1;
            if (capacity != 16'd0)
            begin
                seq.len = jse_pkg::LEN_ONE;
            end
        end
        else if (room_short)
        begin
            if (esc_chr != jse_pkg::CHR_NUL)
            begin
                seq.data[0] = jse_pkg::CHR_BACKSLASH;
                seq.data[1] = esc_chr;
                seq.len     = jse_pkg::LEN_SHORT_ESC;
            end
            else if (in_byte < jse_pkg::CHR_SPACE)
            begin
                // Unicode escape is dropped whole when it does not fit.
                if (room_long)
                begin
                    seq.data[0] = jse_pkg::CHR_BACKSLASH;
                    seq.data[1] = jse_pkg::CHR_LOWER_U;
                    seq.data[2] = jse_pkg::CHR_ZERO;
                    seq.data[3] = jse_pkg::CHR_ZERO;
                    seq.data[4] = jse_pkg::hex_digit(in_byte[7:4]);
                    seq.data[5] = jse_pkg::hex_digit(in_byte[3:0]);
                    seq.len     = jse_pkg::LEN_LONG_ESC;
                end
            end
            else
            begin
                seq.data[0] = in_byte;
                seq.len     = jse_pkg::LEN_ONE;
            end
        end
    end

    // The end byte restarts the count; otherwise it grows by what was emitted.
    assign count_next = (in_byte == jse_pkg::CHR_NUL) ? 16'd0
                      : count + {13'd0, seq.len};

endmodule

FILE: hw/rtl/json_string_escaper.sv
`timescale 1ns / 1ps

// Escapes a zero-terminated byte string for a JSON string literal. One byte
// is taken per transaction; it expands to zero, one, two or six output bytes,
// and the end byte gives a single zero byte flagged is_last (none when the
// capacity is zero). The output leaves one byte per cycle through an output
// register while out_stall is low; no new input byte is taken before every
// byte of the current sequence has been loaded into the output register. A
// new byte is taken in the same cycle as the last byte of the previous
// sequence moves to the output register. The capacity register is written
// through the cfg channel, which is always ready, and must only change while
// the block is idle.
module json_string_escaper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        is_last
);

`include "json_string_escaper_macros.svh"

    logic [15:0]   capacity_reg;
    logic [15:0]   count_reg;
    logic [15:0]   count_next;
    jse_pkg::seq_t seq;

    logic [jse_pkg::SEQ_MAX-1:0][7:0] buf_reg;
    logic [jse_pkg::SEQ_MAX-1:0][7:0] buf_next;
    logic [jse_pkg::LEN_W-1:0]        rem_reg;
    logic [jse_pkg::LEN_W-1:0]        rem_next;
    logic                             last_reg;
    logic                             last_next;
    logic                             busy_reg;
    logic                             busy_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [7:0]                       out_byte_reg;
    logic                             is_last_reg;

    logic in_accept;
    logic out_load;
    logic final_load;

    // Byte expansion for the incoming transaction.
    jse_encode u_encode (
        .in_byte    (in_byte),
        .capacity   (capacity_reg),
        .count      (count_reg),
        .seq        (seq),
        .count_next (count_next)
    );

    // Handshake control.
    assign cfg_ready  = 1'b1;
    assign out_load   = busy_reg && (!out_valid_reg || !out_stall);
    assign final_load = out_load && (rem_reg == jse_pkg::LEN_ONE);
    assign in_stall   = busy_reg && !final_load;
    assign in_accept  = in_valid && !in_stall;

    // Sequence buffer: load on an accept with a non-empty sequence, otherwise shift one byte per load.
    always_comb
    begin
        buf_next  = buf_reg;
        rem_next  = rem_reg;
        last_next = last_reg;
        busy_next = busy_reg;
        if (out_load)
        begin
            buf_next  = {8'h00, buf_reg[jse_pkg::SEQ_MAX-1:1]};
            rem_next  = rem_reg - jse_pkg::LEN_ONE;
            busy_next = (rem_reg != jse_pkg::LEN_ONE);
        end
        if (in_accept && (seq.len != jse_pkg::LEN_NONE))
        begin
            buf_next  = seq.data;
            rem_next  = seq.len;
            last_next = seq.last;
            busy_next = 1'b1;
        end
    end

    // Output register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= 16'd256;
            count_reg     <= 16'd0;
            rem_reg       <= jse_pkg::LEN_NONE;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if (in_accept)
            begin
                count_reg <= count_next;
            end
            rem_reg       <= rem_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        last_reg <= last_next;
        if (out_load)
        begin
            out_byte_reg <= buf_reg[0];
            is_last_reg  <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_last   = is_last_reg;

    // Checks on the buffer and count bookkeeping.
    `JSE_ASSERT_NOW(a_busy_rem, 1'b1, busy_reg == (rem_reg != jse_pkg::LEN_NONE),
        "busy flag disagrees with remaining byte count")
    `JSE_ASSERT_NOW(a_idle_ready, !busy_reg, !in_stall,
        "input stalled while the sequence buffer is empty")
    `JSE_ASSERT_NOW(a_term_zero, out_valid_reg && is_last_reg,
        out_byte_reg == jse_pkg::CHR_NUL,
        "terminator marked last carries a non-zero byte")
    `JSE_ASSERT_NEXT(a_end_clears, in_accept && (in_byte == jse_pkg::CHR_NUL),
        count_reg == 16'd0,
        "end byte did not clear the written count")

endmodule
